### sv/pafp_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and reset values for the focal phase pipeline.
// No dependencies; imported by pafp_sqrt and phased_array_focus_phase.
package pafp_pkg;

    // Field widths.
    localparam int IDX_W   = 9;
    localparam int COORD_W = 16;
    localparam int DIFF_W  = 16;   // magnitude of a coordinate difference
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int RAD_W   = SQ_W + 2;   // sum of three squares
    localparam int ROOT_W  = RAD_W / 2;
    localparam int TPM_W   = 16;
    localparam int PROD_W  = ROOT_W + TPM_W;
    localparam int FRAC_W  = 16;
    localparam int FRAC_LSB = 8;
    localparam int PHASE_W = 17;

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Default array size.
    localparam int NUM_ELEMENTS_DEF = 512;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCUS_X         = 3'd0,
        CFG_FOCUS_Y         = 3'd1,
        CFG_FOCUS_Z         = 3'd2,
        CFG_TURNS_PER_METRE = 3'd3
    } cfg_index_t;

    // Register reset values.
    localparam logic signed [COORD_W-1:0] FOCUS_X_RST = 16'sd0;
    localparam logic signed [COORD_W-1:0] FOCUS_Y_RST = 16'sd0;
    localparam logic signed [COORD_W-1:0] FOCUS_Z_RST = 16'sd5243;
    localparam logic [TPM_W-1:0]          TPM_RST     = 16'd29824;

endpackage

### sv/pafp_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit resolved per register stage.
// Depends on pafp_pkg for the radicand, root and tag widths.
module pafp_sqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [pafp_pkg::RAD_W-1:0]   in_radicand,
    input  logic [pafp_pkg::IDX_W-1:0]   in_tag,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pafp_pkg::ROOT_W-1:0]  out_root,
    output logic [pafp_pkg::IDX_W-1:0]   out_tag
);
    import pafp_pkg::*;

    localparam int NSTG  = ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    // Per-stage registers.
    logic                valid_reg [NSTG];
    logic [REM_W-1:0]    rem_reg   [NSTG];
    logic [ROOT_W-1:0]   root_reg  [NSTG];
    logic [RAD_W-1:0]    rad_reg   [NSTG];
    logic [IDX_W-1:0]    tag_reg   [NSTG];

    // Per-stage next values and load enables.
    logic [REM_W-1:0]    rem_next  [NSTG];
    logic [ROOT_W-1:0]   root_next [NSTG];
    logic                stg_ready [NSTG + 1];

    assign stg_ready[NSTG] = out_ready;
    assign in_ready        = stg_ready[0];

    genvar i;
    generate
        for (i = 0; i < NSTG; i++) begin : g_stage
            logic [REM_W-1:0]  cur_rem;
            logic [ROOT_W-1:0] cur_root;
            logic [RAD_W-1:0]  cur_rad;
            logic [IDX_W-1:0]  cur_tag;
            logic              cur_valid;
            logic [REM_W-1:0]  rem_sh;
            logic [REM_W-1:0]  trial;
            logic              fits;

            // Source of this stage: the input port or the stage before.
            if (i == 0) begin : g_first
                assign cur_rem   = '0;
                assign cur_root  = '0;
                assign cur_rad   = in_radicand;
                assign cur_tag   = in_tag;
                assign cur_valid = in_valid;
            end
            else begin : g_next
                assign cur_rem   = rem_reg[i-1];
                assign cur_root  = root_reg[i-1];
                assign cur_rad   = rad_reg[i-1];
                assign cur_tag   = tag_reg[i-1];
                assign cur_valid = valid_reg[i-1];
            end

            // Bring down the next bit pair and try the trial subtrahend 4r+1.
            always_comb
            begin
                rem_sh  = {cur_rem[REM_W-3:0], cur_rad[RAD_W-1-2*i -: 2]};
                trial   = {cur_root, 2'b01};
                fits    = (rem_sh >= trial);
                rem_next[i]  = fits ? (rem_sh - trial) : rem_sh;
                root_next[i] = {cur_root[ROOT_W-2:0], fits};
            end

            // A stage loads when empty or when its content moves on.
            assign stg_ready[i] = !valid_reg[i] || stg_ready[i+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[i] <= 1'b0;
                end
                else if (stg_ready[i])
                begin
                    valid_reg[i] <= cur_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (stg_ready[i] && cur_valid)
                begin
                    rem_reg[i]  <= rem_next[i];
                    root_reg[i] <= root_next[i];
                    rad_reg[i]  <= cur_rad;
                    tag_reg[i]  <= cur_tag;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[NSTG-1];
    assign out_root  = root_reg[NSTG-1];
    assign out_tag   = tag_reg[NSTG-1];

    // The finished root and remainder reconstruct the radicand exactly.
    a_root_exact: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((RAD_W + 2)'(out_root) * (RAD_W + 2)'(out_root)
                       + (RAD_W + 2)'(rem_reg[NSTG-1]))
                      == (RAD_W + 2)'(rad_reg[NSTG-1]))
        else $error("square root does not reconstruct its radicand");

    // The remainder never exceeds twice the root, so the root is the floor.
    a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rem_reg[NSTG-1] <= {1'b0, out_root, 1'b0}))
        else $error("square root remainder too large");

    // Back pressure reaches the input only once every stage holds an item.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (valid_reg[0] && out_valid && !out_ready))
        else $error("square root stalled with a free stage");

endmodule

### sv/phased_array_focus_phase.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle unless m_axis stalls; every stage holds
// one item and loads whenever it is empty or its item moves on, so bubbles
// close up under stall.
// The 17 root stages of pafp_sqrt set the depth, one root bit per stage.
// Reset clears all valid bits and loads the focal point and wavenumber defaults.
// Top level: focal drive phase pipeline; depends on pafp_pkg and pafp_sqrt.
module phased_array_focus_phase
#(
    parameter int NUM_ELEMENTS = pafp_pkg::NUM_ELEMENTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pafp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pafp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [8:0] element_index, [24:9] elem_x, [40:25] elem_y, [56:41] elem_z
    input  logic [pafp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [8:0] out_index, [25:9] phase
    output logic [pafp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import pafp_pkg::*;

    localparam logic [12:0] NUM_LIM = 13'(NUM_ELEMENTS);

    // Configuration registers.
    logic signed [COORD_W-1:0] focus_x_reg;
    logic signed [COORD_W-1:0] focus_y_reg;
    logic signed [COORD_W-1:0] focus_z_reg;
    logic [TPM_W-1:0]          tpm_reg;

    assign cfg_ready = 1'b1;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focus_x_reg <= FOCUS_X_RST;
            focus_y_reg <= FOCUS_Y_RST;
            focus_z_reg <= FOCUS_Z_RST;
            tpm_reg     <= TPM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FOCUS_X:         focus_x_reg <= cfg_data;
                CFG_FOCUS_Y:         focus_y_reg <= cfg_data;
                CFG_FOCUS_Z:         focus_z_reg <= cfg_data;
                CFG_TURNS_PER_METRE: tpm_reg     <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Input field unpacking.
    logic [IDX_W-1:0]          in_idx;
    logic signed [COORD_W-1:0] in_x;
    logic signed [COORD_W-1:0] in_y;
    logic signed [COORD_W-1:0] in_z;
    logic                      in_ok;

    assign in_idx = s_axis_tdata[8:0];
    assign in_x   = s_axis_tdata[24:9];
    assign in_y   = s_axis_tdata[40:25];
    assign in_z   = s_axis_tdata[56:41];
    assign in_ok  = ({4'b0, in_idx} < NUM_LIM);

    // Stage load enables, from the output back to the input.
    logic a_ready, b_ready, c_ready, d_ready, e_ready;
    logic sq_in_ready;

    // Stage A: absolute coordinate differences.
    logic                a_valid_reg;
    logic [IDX_W-1:0]    a_idx_reg;
    logic [DIFF_W-1:0]   a_dx_reg, a_dy_reg, a_dz_reg;
    logic [DIFF_W-1:0]   a_dx_next, a_dy_next, a_dz_next;

    function automatic logic [DIFF_W-1:0] abs_diff(logic signed [COORD_W-1:0] p,
                                                    logic signed [COORD_W-1:0] f);
        logic signed [COORD_W:0] d;
        logic        [COORD_W:0] m;
        d = {p[COORD_W-1], p} - {f[COORD_W-1], f};
        m = d[COORD_W] ? -d : d;
        return m[DIFF_W-1:0];
    endfunction

    assign a_dx_next = abs_diff(in_x, focus_x_reg);
    assign a_dy_next = abs_diff(in_y, focus_y_reg);
    assign a_dz_next = abs_diff(in_z, focus_z_reg);
    assign a_ready   = !a_valid_reg || b_ready;
    assign s_axis_tready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            a_valid_reg <= s_axis_tvalid && in_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && s_axis_tvalid)
        begin
            a_idx_reg <= in_idx;
            a_dx_reg  <= a_dx_next;
            a_dy_reg  <= a_dy_next;
            a_dz_reg  <= a_dz_next;
        end
    end

    // Stage B: three squares.
    logic              b_valid_reg;
    logic [IDX_W-1:0]  b_idx_reg;
    logic [SQ_W-1:0]   b_sx_reg, b_sy_reg, b_sz_reg;

    assign b_ready = !b_valid_reg || c_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_ready && a_valid_reg)
        begin
            b_idx_reg <= a_idx_reg;
            b_sx_reg  <= a_dx_reg * a_dx_reg;
            b_sy_reg  <= a_dy_reg * a_dy_reg;
            b_sz_reg  <= a_dz_reg * a_dz_reg;
        end
    end

    // Stage C: sum of squares.
    logic              c_valid_reg;
    logic [IDX_W-1:0]  c_idx_reg;
    logic [RAD_W-1:0]  c_sum_reg;

    assign c_ready = !c_valid_reg || sq_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_ready)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_ready && b_valid_reg)
        begin
            c_idx_reg <= b_idx_reg;
            c_sum_reg <= RAD_W'(b_sx_reg) + RAD_W'(b_sy_reg) + RAD_W'(b_sz_reg);
        end
    end

    // Distance: floor square root of the sum.
    logic              sq_out_valid;
    logic [ROOT_W-1:0] sq_root;
    logic [IDX_W-1:0]  sq_idx;

    pafp_sqrt u_sqrt
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (c_valid_reg),
        .in_ready    (sq_in_ready),
        .in_radicand (c_sum_reg),
        .in_tag      (c_idx_reg),
        .out_valid   (sq_out_valid),
        .out_ready   (d_ready),
        .out_root    (sq_root),
        .out_tag     (sq_idx)
    );

    // Stage D: distance times wavenumber.
    logic              d_valid_reg;
    logic [IDX_W-1:0]  d_idx_reg;
    logic [PROD_W-1:0] d_prod_reg;

    assign d_ready = !d_valid_reg || e_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (d_ready)
        begin
            d_valid_reg <= sq_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_ready && sq_out_valid)
        begin
            d_idx_reg  <= sq_idx;
            d_prod_reg <= PROD_W'(sq_root) * PROD_W'(tpm_reg);
        end
    end

    // Stage E: drop whole turns, negate, and hold the result for the sink.
    logic                       e_valid_reg;
    logic [IDX_W-1:0]           e_idx_reg;
    logic [PHASE_W-1:0]         e_phase_reg;
    logic [PHASE_W-1:0]         e_phase_next;

    assign e_phase_next = PHASE_W'(0) - {1'b0, d_prod_reg[FRAC_LSB +: FRAC_W]};
    assign e_ready      = !e_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (e_ready)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (e_ready && d_valid_reg)
        begin
            e_idx_reg   <= d_idx_reg;
            e_phase_reg <= e_phase_next;
        end
    end

    assign m_axis_tvalid = e_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - IDX_W - PHASE_W){1'b0}}, e_phase_reg, e_idx_reg};

    // An index outside the array never enters the pipeline.
    a_drop_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !in_ok) |=> !a_valid_reg)
        else $error("out-of-range element entered the pipeline");

    // Results carry only indexes inside the array.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ({4'b0, e_idx_reg} < NUM_LIM))
        else $error("result carries an out-of-range index");

    // The phase is zero or strictly negative, never a full turn.
    a_phase_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (e_phase_reg == '0 || (e_phase_reg[PHASE_W-1]
                           && e_phase_reg != {1'b1, {(PHASE_W-1){1'b0}}})))
        else $error("phase outside one negative turn");

    // A result waiting at the output does not block a free input stage.
    a_no_idle_block: assert property (@(posedge clk) disable iff (!rst_n)
        !a_valid_reg |-> s_axis_tready)
        else $error("input blocked with an empty first stage");

endmodule
